>>> sv/assert_macros.svh
// Assertion macros shared by the Bezier evaluator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define BEZ_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error(msg);

// checked at every edge, reset included
`define BEZ_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error(msg);

`endif

>>> sv/bez_pkg.sv
// Shared types and constants for the cubic Bezier evaluator/splitter.
// No dependencies.
package bez_pkg;

    localparam int T_IN_W    = 17;
    localparam int OUT_W     = 16;
    localparam int REG_W     = 48;
    localparam int SLOT_W    = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic
    {
        FUNC_EVAL  = 1'b0,
        FUNC_SPLIT = 1'b1
    } bez_func_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_CTRL_POINT_0 = 2'd0,
        CFG_CTRL_POINT_1 = 2'd1,
        CFG_CTRL_POINT_2 = 2'd2,
        CFG_CTRL_POINT_3 = 2'd3
    } bez_cfg_idx_t;

    // output slot codes of a split: P0, Q0, R0, S, S, R1, Q2, P3
    localparam logic [SLOT_W-1:0] SLOT_START   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_Q0      = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_R0      = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_S_LEFT  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_S_RIGHT = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_R1      = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_Q2      = 3'd6;
    localparam logic [SLOT_W-1:0] SLOT_END     = 3'd7;

    // head of the front queue as seen by the back end
    typedef struct packed
    {
        logic      valid;
        bez_func_t func;
    } bez_head_t;

endpackage

>>> sv/bez_front.sv
// Front end: accepts input beats, clamps t to one and queues them (2 entries).
// Depends on bez_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bez_front
    import bez_pkg::*;
#(
    parameter int T_FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [T_IN_W-1:0]  t,
    input  logic               pop,
    output bez_head_t          head,
    output logic [T_FRAC_BITS:0] head_t
);

    localparam int TW    = T_FRAC_BITS + 1;
    localparam int CMPW  = (TW > T_IN_W) ? TW : T_IN_W;
    localparam int DEPTH = 2;

    logic [CMPW-1:0] t_wide;
    logic [CMPW-1:0] one_wide;
    logic [TW-1:0]   t_clamp;
    logic            push;

    bez_func_t     func_q [DEPTH];
    logic [TW-1:0] t_q    [DEPTH];

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;

    assign t_wide   = CMPW'(t);
    assign one_wide = CMPW'(1) << T_FRAC_BITS;
    assign t_clamp  = (t_wide > one_wide) ? TW'(one_wide) : TW'(t_wide);

    assign in_stall = (count_reg == 2'(DEPTH));
    assign push     = in_valid && !in_stall;

    assign head.valid = (count_reg != 2'd0);
    assign head.func  = func_q[rd_ptr_reg];
    assign head_t     = t_q[rd_ptr_reg];

    always_comb
    begin
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            func_q[wr_ptr_reg] <= bez_func_t'(func);
            t_q[wr_ptr_reg]    <= t_clamp;
        end
    end

    `BEZ_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> count_reg != 2'd0, "pop from empty queue")
    `BEZ_ASSERT_ALWAYS(a_count_range, clk, rst_n |-> count_reg != 2'd3, "queue count out of range")
    `BEZ_ASSERT(a_push_pop_count, clk, rst_n,
        push && !pop |=> count_reg == 2'($past(count_reg) + 2'd1), "queue count lost a beat")

endmodule

>>> sv/bez_lerp.sv
// Three-coordinate fixed-point lerp: round(a + (b - a) * t / 2^T_FRAC_BITS).
// No dependencies; one multiplier per coordinate, purely combinational.
module bez_lerp
#(
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
)
(
    input  logic [3*COORD_WIDTH-1:0] a,
    input  logic [3*COORD_WIDTH-1:0] b,
    input  logic [T_FRAC_BITS:0]     t,
    output logic [3*COORD_WIDTH-1:0] r
);

    localparam int CW    = COORD_WIDTH;
    localparam int PRODW = COORD_WIDTH + T_FRAC_BITS + 3;
    localparam logic [PRODW-1:0] HALF = PRODW'(1) << (T_FRAC_BITS - 1);

    for (genvar k = 0; k < 3; k++)
    begin : g_coord
        logic signed [CW-1:0]    ak;
        logic signed [CW-1:0]    bk;
        logic signed [CW:0]      d;
        logic signed [PRODW-1:0] prod;
        logic signed [PRODW-1:0] sum;
        logic signed [CW:0]      step;
        logic        [CW:0]      rs;

        assign ak   = a[k*CW +: CW];
        assign bk   = b[k*CW +: CW];
        assign d    = {bk[CW-1], bk} - {ak[CW-1], ak};
        assign prod = PRODW'(d) * PRODW'(signed'({1'b0, t}));
        assign sum  = prod + signed'(HALF);
        assign step = (CW+1)'(sum >>> T_FRAC_BITS);
        assign rs   = {ak[CW-1], ak} + step;
        assign r[k*CW +: CW] = rs[CW-1:0];
    end

endmodule

>>> sv/bez_back.sv
// Back end: three lerp stages of de Casteljau and the output beat sequencer.
// Depends on bez_pkg, bez_lerp and assert_macros.svh.
`include "assert_macros.svh"

module bez_back
    import bez_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  bez_head_t               head,
    input  logic [T_FRAC_BITS:0]    head_t,
    output logic                    pop,
    input  logic [3*COORD_WIDTH-1:0] p0,
    input  logic [3*COORD_WIDTH-1:0] p1,
    input  logic [3*COORD_WIDTH-1:0] p2,
    input  logic [3*COORD_WIDTH-1:0] p3,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] point_x,
    output logic signed [OUT_W-1:0] point_y,
    output logic signed [OUT_W-1:0] point_z,
    output logic [SLOT_W-1:0]       point_slot,
    output logic                    last_point
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 3 * COORD_WIDTH;
    localparam int TW = T_FRAC_BITS + 1;

    logic adv;
    logic e_free;
    logic beat;

    // stage 1: Q level
    logic [PW-1:0] q0_next, q1_next, q2_next;
    logic [PW-1:0] q0_reg, q1_reg, q2_reg;
    logic [TW-1:0] t1_reg;
    bez_func_t     func1_reg;
    logic          v1_reg, v1_next;

    // stage 2: R level
    logic [PW-1:0] r0_next, r1_next;
    logic [PW-1:0] r0_reg, r1_reg, q0_s2_reg, q2_s2_reg;
    logic [TW-1:0] t2_reg;
    bez_func_t     func2_reg;
    logic          v2_reg, v2_next;

    // stage 3: S level
    logic [PW-1:0] s_next;
    logic [PW-1:0] s_reg, r0_s3_reg, r1_s3_reg, q0_s3_reg, q2_s3_reg;
    bez_func_t     func3_reg;
    logic          v3_reg, v3_next;

    // output sequencer
    logic [PW-1:0]     e_s_reg, e_r0_reg, e_r1_reg, e_q0_reg, e_q2_reg;
    bez_func_t         e_func_reg;
    logic              e_valid_reg, e_valid_next;
    logic [SLOT_W-1:0] e_slot_reg, e_slot_next;
    logic [PW-1:0]     sel_pt;
    logic signed [CW-1:0] cx, cy, cz;

    bez_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_q0
        (.a(p0), .b(p1), .t(head_t), .r(q0_next));
    bez_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_q1
        (.a(p1), .b(p2), .t(head_t), .r(q1_next));
    bez_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_q2
        (.a(p2), .b(p3), .t(head_t), .r(q2_next));
    bez_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_r0
        (.a(q0_reg), .b(q1_reg), .t(t1_reg), .r(r0_next));
    bez_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_r1
        (.a(q1_reg), .b(q2_reg), .t(t1_reg), .r(r1_next));
    bez_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_s
        (.a(r0_reg), .b(r1_reg), .t(t2_reg), .r(s_next));

    assign out_valid  = e_valid_reg;
    assign last_point = (e_func_reg == FUNC_EVAL) || (e_slot_reg == SLOT_END);
    assign beat       = e_valid_reg && !out_stall;
    assign e_free     = !e_valid_reg || (beat && last_point);
    assign adv        = !v3_reg || e_free;
    assign pop        = adv && head.valid;

    always_comb
    begin
        v1_next = adv ? head.valid : v1_reg;
        v2_next = adv ? v1_reg     : v2_reg;
        v3_next = adv ? v2_reg     : v3_reg;
    end

    always_comb
    begin
        e_valid_next = e_valid_reg;
        e_slot_next  = e_slot_reg;
        if (e_free)
        begin
            e_valid_next = v3_reg;
            e_slot_next  = SLOT_START;
        end
        else if (beat)
        begin
            e_slot_next = SLOT_W'(e_slot_reg + 1'b1);
        end
    end

    always_comb
    begin
        sel_pt = e_s_reg;
        case (e_slot_reg)
            SLOT_START:   sel_pt = (e_func_reg == FUNC_EVAL) ? e_s_reg : p0;
            SLOT_Q0:      sel_pt = e_q0_reg;
            SLOT_R0:      sel_pt = e_r0_reg;
            SLOT_S_LEFT:  sel_pt = e_s_reg;
            SLOT_S_RIGHT: sel_pt = e_s_reg;
            SLOT_R1:      sel_pt = e_r1_reg;
            SLOT_Q2:      sel_pt = e_q2_reg;
            SLOT_END:     sel_pt = p3;
            default:      sel_pt = e_s_reg;
        endcase
    end

    assign cx         = sel_pt[0*CW +: CW];
    assign cy         = sel_pt[1*CW +: CW];
    assign cz         = sel_pt[2*CW +: CW];
    assign point_x    = OUT_W'(cx);
    assign point_y    = OUT_W'(cy);
    assign point_z    = OUT_W'(cz);
    assign point_slot = e_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            e_valid_reg <= 1'b0;
            e_slot_reg  <= SLOT_START;
        end
        else
        begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            e_valid_reg <= e_valid_next;
            e_slot_reg  <= e_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q0_reg    <= q0_next;
            q1_reg    <= q1_next;
            q2_reg    <= q2_next;
            t1_reg    <= head_t;
            func1_reg <= head.func;

            r0_reg    <= r0_next;
            r1_reg    <= r1_next;
            q0_s2_reg <= q0_reg;
            q2_s2_reg <= q2_reg;
            t2_reg    <= t1_reg;
            func2_reg <= func1_reg;

            s_reg     <= s_next;
            r0_s3_reg <= r0_reg;
            r1_s3_reg <= r1_reg;
            q0_s3_reg <= q0_s2_reg;
            q2_s3_reg <= q2_s2_reg;
            func3_reg <= func2_reg;
        end
        if (e_free)
        begin
            e_s_reg    <= s_reg;
            e_r0_reg   <= r0_s3_reg;
            e_r1_reg   <= r1_s3_reg;
            e_q0_reg   <= q0_s3_reg;
            e_q2_reg   <= q2_s3_reg;
            e_func_reg <= func3_reg;
        end
    end

    `BEZ_ASSERT(a_slot_advance, clk, rst_n,
        beat && !last_point |=> out_valid && point_slot == SLOT_W'($past(point_slot) + 1'b1),
        "split slot did not advance after a beat")
    `BEZ_ASSERT(a_s3_hold, clk, rst_n,
        v3_reg && !adv |=> v3_reg && $stable(s_reg),
        "stage 3 result lost while sequencer busy")
    `BEZ_ASSERT(a_eval_single, clk, rst_n,
        out_valid && e_func_reg == FUNC_EVAL |-> point_slot == SLOT_START,
        "evaluate beat with nonzero slot")

endmodule

>>> sv/cubic_bezier_eval_split.sv
// Top level of the cubic Bezier evaluator/splitter: control point registers
// and the front/back pipeline. Depends on bez_pkg, bez_front and bez_back.
//
// Usage:
//   Input channel (in_valid/in_stall, func, t): one beat per operation.
//   func = evaluate gives one point beat; func = split gives eight beats,
//   slots 0..7 (left half P0,Q0,R0,S then right half S,R1,Q2,P3).
//   t above one is taken as one. last_point marks the final beat of an item.
//   Output channel (out_valid/out_stall): point_x/y/z, point_slot, last_point.
//   Control points are written through cfg_wen/cfg_index/cfg_data; the user
//   must do so only while idle; the block itself does not enforce it.
// Throughput: evaluates stream at one per cycle through the three lerp
//   stages unless out_stall or a split holds them; a split holds the output
//   sequencer until its last beat is taken, so splits run one at a time.
// A 2-entry queue sits between input and the lerp pipeline; out_stall freezes
//   the sequencer, the pipeline fills up behind it, and in_stall rises once
//   the queue is full.
// Reset clears all control points to zero and empties the pipeline.
module cubic_bezier_eval_split
    import bez_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wen,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [REG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [T_IN_W-1:0]       t,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] point_x,
    output logic signed [OUT_W-1:0] point_y,
    output logic signed [OUT_W-1:0] point_z,
    output logic [SLOT_W-1:0]       point_slot,
    output logic                    last_point
);

    localparam int PW = 3 * COORD_WIDTH;

    logic [REG_W-1:0] cp0_reg, cp1_reg, cp2_reg, cp3_reg;
    logic [REG_W-1:0] cp0_next, cp1_next, cp2_next, cp3_next;
    logic [PW-1:0]    p0, p1, p2, p3;

    bez_head_t              head;
    logic [T_FRAC_BITS:0]   head_t;
    logic                   pop;

    always_comb
    begin
        cp0_next = cp0_reg;
        cp1_next = cp1_reg;
        cp2_next = cp2_reg;
        cp3_next = cp3_reg;
        if (cfg_wen)
        begin
            unique case (bez_cfg_idx_t'(cfg_index))
                CFG_CTRL_POINT_0: cp0_next = cfg_data;
                CFG_CTRL_POINT_1: cp1_next = cfg_data;
                CFG_CTRL_POINT_2: cp2_next = cfg_data;
                CFG_CTRL_POINT_3: cp3_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp0_reg <= '0;
            cp1_reg <= '0;
            cp2_reg <= '0;
            cp3_reg <= '0;
        end
        else
        begin
            cp0_reg <= cp0_next;
            cp1_reg <= cp1_next;
            cp2_reg <= cp2_next;
            cp3_reg <= cp3_next;
        end
    end

    // packed x/y/z; bits beyond the register read as zero
    assign p0 = PW'(cp0_reg);
    assign p1 = PW'(cp1_reg);
    assign p2 = PW'(cp2_reg);
    assign p3 = PW'(cp3_reg);

    bez_front #(.T_FRAC_BITS(T_FRAC_BITS)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .t        (t),
        .pop      (pop),
        .head     (head),
        .head_t   (head_t)
    );

    bez_back #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_t     (head_t),
        .pop        (pop),
        .p0         (p0),
        .p1         (p1),
        .p2         (p2),
        .p3         (p3),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .point_slot (point_slot),
        .last_point (last_point)
    );

endmodule
